[design/dca_pkg.sv]
// Package for the device capacity allocator: widths, register indexes,
// beat structs and the capacity arithmetic used by the device cells.
// No dependencies.
package dca_pkg;

    localparam int MAX_DEVS = 12;
    localparam int IDX_W    = 4;
    localparam int USE_W    = 7;
    localparam int ALLOC_W  = 8;
    localparam int REQ_W    = 7;
    localparam int CLS_W    = 3;
    localparam int TIME_W   = 32;
    localparam int WIN_W    = 8;
    localparam int TOT_W    = 11;
    localparam int SLK_W    = 7;
    localparam int PROD_W   = 14;

    // Input and output tdata widths
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 16;

    // Configuration register indexes
    localparam logic CFG_DEVICE_COUNT  = 1'b0;
    localparam logic CFG_REPEAT_WINDOW = 1'b1;

    // Item kinds carried in tuser
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    // Selection modes
    localparam logic MODE_BALANCE = 1'b0;
    localparam logic MODE_LOWPWR  = 1'b1;

    localparam logic [USE_W-1:0] USAGE_MAX    = 7'd100;
    localparam logic [SLK_W-1:0] BEST_LOWPWR  = 7'd100;
    localparam logic [SLK_W-1:0] BEST_BALANCE = 7'd0;
    localparam logic [ALLOC_W-1:0] ALLOC_MAX  = 8'd255;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd3;

    // floor(x / 100) = (x * 5243) >> 19 for every x up to 9600
    localparam int DIV_SHIFT = 19;
    localparam logic [12:0] RECIP_100 = 13'd5243;

    // Scan beat handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               clear;
        logic [SLK_W-1:0]   best;
        logic [IDX_W-1:0]   sel;
        logic               hit;
        logic [TOT_W-1:0]   total;
    } t_tok;

    // Request fields held steady for the whole scan
    typedef struct packed {
        logic               mode;
        logic [CLS_W-1:0]   cls;
        logic [REQ_W-1:0]   req;
        logic [IDX_W-1:0]   ndev;
    } t_req;

    // Usage load broadcast
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   idx;
        logic [USE_W-1:0]   usage;
    } t_load;

    // Allocation commit broadcast at the end of a scan
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   sel;
        logic [REQ_W-1:0]   req;
    } t_commit;

    // Stream scale per resolution class
    function automatic logic [USE_W-1:0] class_scale(input logic [CLS_W-1:0] cls);
        logic [USE_W-1:0] k;
        case (cls)
            3'd1:    k = 7'd96;
            3'd2:    k = 7'd36;
            3'd3:    k = 7'd16;
            3'd4:    k = 7'd4;
            default: k = 7'd0;
        endcase
        return k;
    endfunction

    // Quotient by 100 through a reciprocal multiply
    function automatic logic [USE_W-1:0] div100(input logic [PROD_W-1:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'(RECIP_100);
        return USE_W'(p >> DIV_SHIFT);
    endfunction

endpackage

[design/device_capacity_allocator.sv]
// Device capacity allocator: a load beat (tuser 0) stores one device's encoder
// usage and posts an all-zero result; a request beat (tuser 1) runs a scan beat
// down a row of MAX_DEVS device cells, one cell per cycle, and its result passes
// through setup, the cell row, capture and the output register. One item is in
// work at a time; tready rises as the result moves into the output register, and
// a finished item waits in post while an older result is not taken.
// Depends on dca_pkg and dca_cell.
module device_capacity_allocator import dca_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config write port
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_addr,
    input  logic [WIN_W-1:0]        i_cfg_wdata,
    // input stream
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // [3:0] device_index, [10:4] usage_percent, [11] mode, [14:12] res_type,
    // [21:15] req_count, [53:22] time_seconds, [55:54] zero
    input  logic [IN_TDATA_W-1:0]   i_s_axis_tdata,
    // [0] cmd
    input  logic                    i_s_axis_tuser,
    // output stream
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // [3:0] selected_device, [14:4] total_capacity, [15] zero
    output logic [OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // [0] found
    output logic                    o_m_axis_tuser
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_SCAN = 4'b0100,
        S_POST = 4'b1000
    } t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_dev_count;
    logic [WIN_W-1:0]   r_window;
    logic               r_prev_mode;
    logic [CLS_W-1:0]   r_prev_cls;
    logic [REQ_W-1:0]   r_prev_req;
    logic [TIME_W-1:0]  r_prev_time;
    logic               r_clear;
    t_req               r_req;
    t_tok               r_tok;
    logic [IDX_W-1:0]   r_res_sel;
    logic               r_res_found;
    logic [TOT_W-1:0]   r_res_total;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_sel;
    logic               r_out_found;
    logic [TOT_W-1:0]   r_out_total;

    logic               w_accept;
    logic [IDX_W-1:0]   w_idx;
    logic [USE_W-1:0]   w_usage;
    logic               w_mode;
    logic [CLS_W-1:0]   w_cls;
    logic [REQ_W-1:0]   w_reqc;
    logic [TIME_W-1:0]  w_now;
    logic [TIME_W:0]    w_diff;
    logic               w_in_window;
    logic               w_repeat;
    logic               w_out_free;
    t_load              w_load;
    t_commit            w_commit;
    t_tok               w_tok [0:MAX_DEVS];

    // Unpack the input beat
    assign w_idx   = i_s_axis_tdata[3:0];
    assign w_usage = i_s_axis_tdata[10:4];
    assign w_mode  = i_s_axis_tdata[11];
    assign w_cls   = i_s_axis_tdata[14:12];
    assign w_reqc  = i_s_axis_tdata[21:15];
    assign w_now   = i_s_axis_tdata[53:22];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // Repeat test: signed time difference below the window
    assign w_diff      = {1'b0, w_now} - {1'b0, r_prev_time};
    assign w_in_window = $signed(w_diff) < $signed({25'd0, r_window});
    assign w_repeat    = (r_prev_mode == w_mode) && (r_prev_cls == w_cls) &&
                         (r_prev_req == w_reqc) && w_in_window;

    // Broadcasts to the cells
    assign w_load.we    = w_accept && (i_s_axis_tuser == CMD_LOAD);
    assign w_load.idx   = w_idx;
    assign w_load.usage = w_usage;

    assign w_commit.en  = w_tok[MAX_DEVS].valid && w_tok[MAX_DEVS].hit;
    assign w_commit.sel = w_tok[MAX_DEVS].sel;
    assign w_commit.req = r_req.req;

    assign w_tok[0] = r_tok;

    // Row of device cells
    for (genvar g = 0; g < MAX_DEVS; g++) begin : g_cell
        dca_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_req      (r_req),
            .i_load     (w_load),
            .i_commit   (w_commit),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_count <= '0;
            r_window    <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DEVICE_COUNT:  r_dev_count <= i_cfg_wdata[IDX_W-1:0];
                CFG_REPEAT_WINDOW: r_window    <= i_cfg_wdata;
                default:           r_window    <= r_window;
            endcase
        end
    end

    // Sequencer: accept, set up, scan, post
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_mode <= 1'b0;
            r_prev_cls  <= '0;
            r_prev_req  <= '0;
            r_prev_time <= '0;
            r_tok.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Launch the scan beat only from setup
            r_tok.valid <= (r_state == S_PREP);
            // Load the output register from post, drop it once taken
            if (r_state == S_POST && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_s_axis_tuser == CMD_LOAD) begin
                            r_res_sel   <= '0;
                            r_res_found <= 1'b0;
                            r_res_total <= '0;
                            r_state     <= S_POST;
                        end else begin
                            r_clear     <= !w_repeat;
                            r_prev_mode <= w_mode;
                            r_prev_cls  <= w_cls;
                            r_prev_req  <= w_reqc;
                            r_prev_time <= w_now;
                            r_req.mode  <= w_mode;
                            r_req.cls   <= w_cls;
                            r_req.req   <= w_reqc;
                            r_req.ndev  <= (r_dev_count > IDX_W'(MAX_DEVS)) ?
                                           IDX_W'(MAX_DEVS) : r_dev_count;
                            r_state     <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_tok.clear <= r_clear;
                    r_tok.best  <= (r_req.mode == MODE_LOWPWR) ? BEST_LOWPWR
                                                               : BEST_BALANCE;
                    r_tok.sel   <= '0;
                    r_tok.hit   <= 1'b0;
                    r_tok.total <= '0;
                    r_state     <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_tok[MAX_DEVS].valid) begin
                        r_res_sel   <= w_tok[MAX_DEVS].hit ? w_tok[MAX_DEVS].sel : '0;
                        r_res_found <= w_tok[MAX_DEVS].hit;
                        r_res_total <= w_tok[MAX_DEVS].total;
                        r_state     <= S_POST;
                    end
                end
                S_POST: begin
                    if (w_out_free) begin
                        r_out_sel   <= r_res_sel;
                        r_out_found <= r_res_found;
                        r_out_total <= r_res_total;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_total, r_out_sel};
    assign o_m_axis_tuser  = r_out_found;

`ifndef SYNTHESIS
    // Scan beat leaves the row exactly when expected
    a_scan_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tuser == CMD_REQUEST) |-> ##14 w_tok[MAX_DEVS].valid)
        else $error("scan beat did not leave the cell row on time");

    // No scan beat outside a scan
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[MAX_DEVS].valid |-> (r_state == S_SCAN))
        else $error("scan beat outside of scan state");

    // Load goes straight to posting
    a_load_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tuser == CMD_LOAD) |=> (r_state == S_POST))
        else $error("load did not move to post");

    // A found result names a real device
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
            (o_m_axis_tdata[3:0] < IDX_W'(MAX_DEVS)))
        else $error("selected device out of range");
`endif

endmodule

[design/dca_cell.sv]
// One device cell: holds the usage and allocated count of one device and
// processes the scan beat as it passes. Depends on dca_pkg.
module dca_cell import dca_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IDX_W-1:0]   i_cell_idx,
    input  t_req               i_req,
    input  t_load              i_load,
    input  t_commit            i_commit,
    input  t_tok               i_tok,
    output t_tok               o_tok
);

    logic [USE_W-1:0]   r_usage;
    logic [ALLOC_W-1:0] r_alloc;
    logic [PROD_W-1:0]  r_prod;
    t_tok               r_tok;

    logic [USE_W-1:0]   w_k;
    logic [USE_W-1:0]   w_usat;
    logic [USE_W-1:0]   w_cap;
    logic [ALLOC_W-1:0] w_alloc;
    logic               w_active;
    logic [9:0]         w_avail;
    logic [9:0]         w_slack;
    logic               w_fits;
    logic               w_better;
    logic [ALLOC_W:0]   w_sum;
    t_tok               n_tok;

    // Capacity and slack for the passing beat
    always_comb begin
        w_k      = class_scale(i_req.cls);
        w_usat   = (r_usage > USAGE_MAX) ? USAGE_MAX : r_usage;
        w_cap    = w_k - div100(r_prod);
        w_alloc  = i_tok.clear ? '0 : r_alloc;
        w_active = (i_cell_idx < i_req.ndev);
        w_avail  = {3'd0, w_cap} - {2'd0, w_alloc};
        w_slack  = w_avail - {3'd0, i_req.req};
        w_fits   = w_active && ($signed(w_avail) >= $signed({3'd0, i_req.req}));
        w_better = (i_req.mode == MODE_LOWPWR) ? (w_slack[SLK_W-1:0] < i_tok.best)
                                               : (w_slack[SLK_W-1:0] > i_tok.best);
        w_sum    = {1'b0, r_alloc} + {2'd0, i_commit.req};
        n_tok    = i_tok;
        if (w_active) begin
            n_tok.total = i_tok.total + {4'd0, w_cap};
        end
        if (w_fits && w_better) begin
            n_tok.best = w_slack[SLK_W-1:0];
            n_tok.sel  = i_cell_idx;
            n_tok.hit  = 1'b1;
        end
    end

    // Scale product, registered: ready in the cycle after the class is set
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_k) * PROD_W'(w_usat);
    end

    // Hand the beat on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.clear <= n_tok.clear;
        r_tok.best  <= n_tok.best;
        r_tok.sel   <= n_tok.sel;
        r_tok.hit   <= n_tok.hit;
        r_tok.total <= n_tok.total;
    end

    // Device state: load, clear on a fresh request, add on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usage <= '0;
            r_alloc <= '0;
        end else begin
            if (i_load.we && i_load.idx == i_cell_idx) begin
                r_usage <= i_load.usage;
            end
            if (i_commit.en && i_commit.sel == i_cell_idx) begin
                r_alloc <= w_sum[ALLOC_W] ? ALLOC_MAX : w_sum[ALLOC_W-1:0];
            end else if (i_tok.valid && i_tok.clear) begin
                r_alloc <= '0;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

[bench/device_capacity_allocator_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for device_capacity_allocator: load and request beats, directed
// then random, are checked against an in-bench model of the device selection logic.
// Depends on dca_pkg and the design sources.
module device_capacity_allocator_tb import dca_pkg::*; ();

    localparam int     CLK_HALF     = 6;
    localparam int     RESET_CYCLES = 9;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     LONG_HOLD    = 300;
    localparam int     MAX_REPORTS  = 10;
    localparam int     PCT_FULL     = 100;
    localparam int     ALLOC_CEIL   = 255;
    localparam longint TIMEOUT_NS   = 10_000_000;

    typedef struct packed {
        logic               cmd;
        logic [IDX_W-1:0]   dev;
        logic [USE_W-1:0]   usage;
        logic               mode;
        logic [CLS_W-1:0]   cls;
        logic [REQ_W-1:0]   req;
        logic [TIME_W-1:0]  tsec;
    } alloc_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   sel;
        logic               found;
        logic [TOT_W-1:0]   total;
    } alloc_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic                   i_cfg_addr = CFG_DEVICE_COUNT;
    logic [WIN_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [3:0] device_index, [10:4] usage_percent, [11] mode, [14:12] res_type,
    // [21:15] req_count, [53:22] time_seconds, [55:54] zero
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    // [0] cmd
    logic                   i_s_axis_tuser = CMD_LOAD;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b1;
    // [3:0] selected_device, [14:4] total_capacity, [15] zero
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    // [0] found
    logic                   o_m_axis_tuser;

    // Model state: registers, per-device stores and the last request shape
    logic [IDX_W-1:0]   cfg_ndev;
    logic [WIN_W-1:0]   cfg_window;
    logic [USE_W-1:0]   usage_mem [MAX_DEVS];
    logic [ALLOC_W-1:0] alloc_mem [MAX_DEVS];
    logic               seen_mode;
    logic [CLS_W-1:0]   seen_cls;
    logic [REQ_W-1:0]   seen_req;
    logic [TIME_W-1:0]  seen_tsec;

    alloc_result_t      pending_results[$];
    int                 mismatches = 0;

    // Sender and receiver pacing controls
    bit                 pace_sender = 1'b1;
    bit                 pace_sink = 1'b1;
    int                 burst_left = 0;
    int                 hold_requests = 0;

    // Random request walk: shape and clock reused so repeats land in the window
    logic               walk_mode = MODE_BALANCE;
    logic [CLS_W-1:0]   walk_cls = 3'd1;
    logic [REQ_W-1:0]   walk_req = '0;
    logic [TIME_W-1:0]  walk_time = '0;

    device_capacity_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Streams per device at zero usage for each resolution class
    function automatic int stream_scale(input logic [CLS_W-1:0] cls);
        case (cls)
            3'd1:    return 96;
            3'd2:    return 36;
            3'd3:    return 16;
            3'd4:    return 4;
            default: return 0;
        endcase
    endfunction

    // Apply one accepted beat to the model and return the result it must produce
    function automatic alloc_result_t predict_alloc(input alloc_item_t it);
        alloc_result_t r;
        longint        since;
        int            n, k, best, u, cap, avail, slack, sel, total, sum;
        bit            hit;
        r = '0;
        if (it.cmd == CMD_LOAD) begin
            if (it.dev < MAX_DEVS)
                usage_mem[it.dev] = it.usage;
            return r;
        end
        // Drop allocations unless this repeats the last request inside the window
        since = longint'(it.tsec) - longint'(seen_tsec);
        if (!(it.mode == seen_mode && it.cls == seen_cls && it.req == seen_req &&
              since < longint'(cfg_window))) begin
            foreach (alloc_mem[d])
                alloc_mem[d] = '0;
        end
        seen_mode = it.mode;
        seen_cls  = it.cls;
        seen_req  = it.req;
        seen_tsec = it.tsec;
        // Scan devices for the best slack
        n     = (cfg_ndev > MAX_DEVS) ? MAX_DEVS : int'(cfg_ndev);
        k     = stream_scale(it.cls);
        best  = (it.mode == MODE_BALANCE) ? 0 : PCT_FULL;
        hit   = 1'b0;
        sel   = 0;
        total = 0;
        for (int d = 0; d < n; d++) begin
            u     = (usage_mem[d] > PCT_FULL) ? PCT_FULL : int'(usage_mem[d]);
            cap   = k - (k * u) / PCT_FULL;
            avail = cap - int'(alloc_mem[d]);
            total += cap;
            if (int'(it.req) <= avail) begin
                slack = avail - int'(it.req);
                if ((it.mode == MODE_BALANCE && slack > best) ||
                    (it.mode == MODE_LOWPWR && slack < best)) begin
                    best = slack;
                    sel  = d;
                    hit  = 1'b1;
                end
            end
        end
        if (hit) begin
            sum = int'(alloc_mem[sel]) + int'(it.req);
            alloc_mem[sel] = (sum > ALLOC_CEIL) ? ALLOC_W'(ALLOC_CEIL) : ALLOC_W'(sum);
        end
        r.sel   = hit ? IDX_W'(sel) : '0;
        r.found = hit;
        r.total = TOT_W'(total);
        return r;
    endfunction

    // Load beat; fields a load does not use carry random junk
    function automatic alloc_item_t make_load(input logic [IDX_W-1:0] dev,
                                              input logic [USE_W-1:0] usage);
        alloc_item_t it;
        it       = alloc_item_t'(55'({$urandom, $urandom}));
        it.cmd   = CMD_LOAD;
        it.dev   = dev;
        it.usage = usage;
        return it;
    endfunction

    // Request beat; device index and usage carry random junk
    function automatic alloc_item_t make_req(input logic mode, input logic [CLS_W-1:0] cls,
                                             input logic [REQ_W-1:0] req,
                                             input logic [TIME_W-1:0] tsec);
        alloc_item_t it;
        it      = alloc_item_t'(55'({$urandom, $urandom}));
        it.cmd  = CMD_REQUEST;
        it.mode = mode;
        it.cls  = cls;
        it.req  = req;
        it.tsec = tsec;
        return it;
    endfunction

    // Mostly repeats of a running request shape with a slow clock, plus loads and noise
    function automatic alloc_item_t rand_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            return make_load(($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 15))
                                                         : IDX_W'($urandom_range(0, 11)),
                             ($urandom_range(0, 4) == 0) ? USE_W'($urandom_range(0, 127))
                                                         : USE_W'($urandom_range(0, 100)));
        end
        case ($urandom_range(0, 19))
            0:       walk_time = $urandom;
            1:       walk_time = walk_time - TIME_W'($urandom_range(1, 300));
            default: walk_time = walk_time + TIME_W'($urandom_range(0, 2));
        endcase
        if (pick >= 72) begin
            walk_mode = 1'($urandom_range(0, 1));
            walk_cls  = ($urandom_range(0, 4) == 0) ? CLS_W'($urandom_range(0, 7))
                                                    : CLS_W'($urandom_range(1, 4));
            case ($urandom_range(0, 9))
                0:       walk_req = REQ_W'($urandom_range(0, 127));
                1, 2:    walk_req = REQ_W'($urandom_range(0, 60));
                default: walk_req = REQ_W'($urandom_range(0, 20));
            endcase
        end
        return make_req(walk_mode, walk_cls, walk_req, walk_time);
    endfunction

    // Offer one beat, hold it until accepted, then record its expected result
    task automatic send_item(input alloc_item_t it);
        if (pace_sender) begin
            if (burst_left == 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, it.tsec, it.req, it.cls, it.mode, it.usage, it.dev};
        i_s_axis_tuser  <= it.cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(predict_alloc(it));
    endtask

    task automatic send_random(input int count);
        repeat (count) send_item(rand_item());
    endtask

    // Stop offering and wait for every outstanding result, then let the block settle
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input logic [WIN_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        if (addr == CFG_DEVICE_COUNT)
            cfg_ndev = value[IDX_W-1:0];
        else
            cfg_window = value;
    endtask

    task automatic do_reset();
        cfg_ndev   = '0;
        cfg_window = WINDOW_RESET;
        foreach (usage_mem[d]) begin
            usage_mem[d] = '0;
            alloc_mem[d] = '0;
        end
        seen_mode = 1'b0;
        seen_cls  = '0;
        seen_req  = '0;
        seen_tsec = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // Field extremes, ignored loads, window edges, no fit, unknown classes, scan limits
    task automatic test_directed();
        write_reg(CFG_DEVICE_COUNT, 8'd12);
        send_item(make_load(4'd0, 7'd0));
        send_item(make_load(4'd11, 7'd100));
        send_item(make_load(4'd5, 7'd127));
        send_item(make_load(4'd15, 7'd127));
        send_item(make_load(4'd12, 7'd55));
        send_item(make_load(4'd3, 7'd50));
        send_item(make_req(MODE_BALANCE, 3'd1, 7'd5, 32'd10));
        send_item(make_req(MODE_BALANCE, 3'd1, 7'd5, 32'd11));
        send_item(make_req(MODE_BALANCE, 3'd1, 7'd5, 32'd14));
        send_item(make_req(MODE_LOWPWR, 3'd1, 7'd5, 32'd14));
        send_item(make_req(MODE_LOWPWR, 3'd1, 7'd5, 32'd5));
        send_item(make_req(MODE_BALANCE, 3'd1, 7'd127, 32'd6));
        send_item(make_req(MODE_BALANCE, 3'd2, 7'd0, 32'd7));
        send_item(make_req(MODE_LOWPWR, 3'd3, 7'd16, 32'd8));
        send_item(make_req(MODE_BALANCE, 3'd4, 7'd4, 32'd9));
        send_item(make_req(MODE_BALANCE, 3'd0, 7'd0, 32'd9));
        send_item(make_req(MODE_LOWPWR, 3'd0, 7'd0, 32'd9));
        send_item(make_req(MODE_BALANCE, 3'd7, 7'd0, 32'hFFFF_FFFF));
        send_item(make_req(MODE_BALANCE, 3'd5, 7'd0, 32'd0));
        send_item(make_req(MODE_LOWPWR, 3'd6, 7'd1, 32'h8000_0000));
        // No devices scanned, then a count above the device row
        wait_drained();
        write_reg(CFG_DEVICE_COUNT, 8'd0);
        send_item(make_req(MODE_LOWPWR, 3'd1, 7'd1, 32'd100));
        wait_drained();
        write_reg(CFG_DEVICE_COUNT, 8'hFF);
        send_item(make_req(MODE_BALANCE, 3'd1, 7'd3, 32'd200));
        // Zero window: an identical request at the same second still clears
        wait_drained();
        write_reg(CFG_REPEAT_WINDOW, 8'd0);
        send_item(make_req(MODE_BALANCE, 3'd1, 7'd3, 32'd200));
        send_item(make_req(MODE_BALANCE, 3'd1, 7'd3, 32'd200));
    endtask

    // Step through register settings, extremes included, with random traffic in each
    task automatic test_config_sweep();
        int ndev_set[8]   = '{12, 1, 0, 15, 7, 12, 12, 4};
        int window_set[8] = '{3, 0, 255, 255, 1, 0, 255, 10};
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            write_reg(CFG_DEVICE_COUNT, WIN_W'(($urandom_range(0, 15) << 4) | ndev_set[p]));
            write_reg(CFG_REPEAT_WINDOW, WIN_W'(window_set[p]));
            pace_sink   = (p % 3) != 2;
            pace_sender = (p % 4) != 3;
            send_random(90);
        end
        pace_sink   = 1'b1;
        pace_sender = 1'b1;
    endtask

    // Long random run at the power-on window with all devices present
    task automatic test_random_traffic();
        wait_drained();
        write_reg(CFG_DEVICE_COUNT, 8'd12);
        write_reg(CFG_REPEAT_WINDOW, 8'd3);
        send_random(300);
        pace_sender = 1'b0;
        pace_sink   = 1'b0;
        send_random(150);
        pace_sender = 1'b1;
        pace_sink   = 1'b1;
        send_random(150);
    endtask

    // Receiver holds off for a long stretch while beats keep coming
    task automatic test_backpressure();
        pace_sender = 1'b0;
        hold_requests++;
        send_random(40);
        pace_sender = 1'b1;
    endtask

    // Sender stops until every result is back, then resumes
    task automatic test_sender_pause();
        send_random(20);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        send_random(20);
    endtask

    initial begin
        do_reset();
        test_directed();
        test_config_sweep();
        test_random_traffic();
        test_backpressure();
        test_sender_pause();
        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Receiver ready: rotating random pattern, free-running stretches, long hold on request
    initial begin : sink_pacer
        int          hold;
        int          taken;
        int          tick;
        logic [15:0] pat;
        hold  = 0;
        taken = 0;
        tick  = 0;
        pat   = '1;
        forever begin
            @(posedge i_clk);
            if (hold_requests != taken) begin
                taken = hold_requests;
                hold  = LONG_HOLD;
            end
            if (tick == 0) begin
                tick = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0:       pat = '1;
                    1:       pat = 16'($urandom);
                    2:       pat = 16'($urandom | $urandom);
                    default: pat = 16'($urandom & $urandom);
                endcase
            end
            tick--;
            pat = {pat[0], pat[15:1]};
            if (hold > 0) begin
                hold--;
                i_m_axis_tready <= 1'b0;
            end else if (!pace_sink) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= pat[0];
            end
        end
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Compare each accepted result beat against the oldest expectation
    always @(posedge i_clk) begin : result_check
        alloc_result_t want;
        alloc_result_t got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.sel   = o_m_axis_tdata[IDX_W-1:0];
            got.total = o_m_axis_tdata[IDX_W +: TOT_W];
            got.found = o_m_axis_tuser;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result: sel %0d found %0b total %0d",
                                        got.sel, got.found, got.total));
            end else begin
                want = pending_results.pop_front();
                if (got.sel !== want.sel || got.found !== want.found ||
                    got.total !== want.total)
                    note_mismatch($sformatf(
                        {"result mismatch: expected sel %0d found %0b total %0d, ",
                         "got sel %0d found %0b total %0d"},
                        want.sel, want.found, want.total, got.sel, got.found, got.total));
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
